### rtl/slfcr_pkg.sv
// ============================================================================
// slfcr_pkg - shared definitions for the SPI length-framed command receiver
// Function codes, register indexes, protocol constants and the result item.
// ============================================================================
`default_nettype none

package slfcr_pkg;

  // Default frame buffer depth
  localparam int BUFFER_DEPTH_DEF = 32;

  // Protocol constants
  localparam logic [7:0] STATUS_REQUEST = 8'hFF;
  localparam logic [7:0] LENGTH_BIAS    = 8'd2;

  // Reset values of the configuration registers
  localparam logic [7:0] STATUS_REPLY_RST  = 8'd0;
  localparam logic [7:0] OVERFLOW_CODE_RST = 8'd0;
  localparam logic [7:0] TIMEOUT_TICKS_RST = 8'd56;

  // Item function codes
  localparam logic [1:0] FUNC_BYTE    = 2'd0;
  localparam logic [1:0] FUNC_TICK    = 2'd1;
  localparam logic [1:0] FUNC_CONSUME = 2'd2;

  // Register indexes (word address)
  localparam logic [1:0] REG_STATUS_REPLY  = 2'd0;
  localparam logic [1:0] REG_OVERFLOW_CODE = 2'd1;
  localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd2;

  // Configuration seen by the control logic
  typedef struct packed {
    logic [7:0] status_reply;
    logic [7:0] overflow_code;
    logic [7:0] timeout_ticks;
  } cfg_t;

  // One result item
  typedef struct packed {
    logic       reply_valid;
    logic [7:0] reply_byte;
    logic       store_valid;
    logic [4:0] store_index;
    logic       frame_done;
    logic [1:0] frame_state;
    logic       timeout_hit;
    logic [7:0] timeout_count;
    logic [7:0] expected_total;
  } result_t;

endpackage

`default_nettype wire

### rtl/spi_length_framed_command_receiver.sv
// ============================================================================
// spi_length_framed_command_receiver - SPI command frame receiver
// Frames SPI bytes by a length byte, answers status requests, runs a watchdog.
// ============================================================================
// Usage:
//   Input channel (in_valid/in_ready): one item per event, in_func selects an
//   SPI byte (in_rx_byte), a timer tick or a command-consumed event.
//   Result channel (out_valid/out_ready): exactly one result item per input
//   item, in order, carrying the reply, store, frame and watchdog status.
//   Configuration: APB port with status_reply at 0x0, overflow_code at 0x4
//   and timeout_ticks at 0x8; pready is tied high, reads return the value.
//   The result item is registered and valid in the cycle after its item is accepted.
//   Throughput: one item per cycle; the frame state register and the buffer
//   write port are updated in the accept cycle, so items follow back to back.
//   The output register holds a result while out_ready is low, and in_ready
//   stays high as long as that result is taken in the same cycle; a stalled
//   receiver stalls the input after one result is held.
//   Reset (rst_n low, synchronous) returns the frame state to idle, clears
//   the counters and loads the register defaults; buffer contents are kept.
// ============================================================================
`default_nettype none

module spi_length_framed_command_receiver #(
  parameter int BUFFER_DEPTH = slfcr_pkg::BUFFER_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_func,
  input  wire logic [7:0]  in_rx_byte,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_reply_valid,
  output logic [7:0]       out_reply_byte,
  output logic             out_store_valid,
  output logic [4:0]       out_store_index,
  output logic             out_frame_done,
  output logic [1:0]       out_frame_state,
  output logic             out_timeout_hit,
  output logic [7:0]       out_timeout_count,
  output logic [7:0]       out_expected_total,
  // configuration port
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  import slfcr_pkg::*;

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int PW = $clog2(BUFFER_DEPTH + 1);

  cfg_t          cfg_r;
  result_t       res;
  result_t       out_r;
  logic          out_valid_r;
  logic          accept;
  logic          cfg_wr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;

  // Configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.status_reply  <= STATUS_REPLY_RST;
      cfg_r.overflow_code <= OVERFLOW_CODE_RST;
      cfg_r.timeout_ticks <= TIMEOUT_TICKS_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_STATUS_REPLY:  cfg_r.status_reply  <= cfg_pwdata[7:0];
        REG_OVERFLOW_CODE: cfg_r.overflow_code <= cfg_pwdata[7:0];
        REG_TIMEOUT_TICKS: cfg_r.timeout_ticks <= cfg_pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (cfg_paddr[3:2])
      REG_STATUS_REPLY:  cfg_prdata = {24'd0, cfg_r.status_reply};
      REG_OVERFLOW_CODE: cfg_prdata = {24'd0, cfg_r.overflow_code};
      REG_TIMEOUT_TICKS: cfg_prdata = {24'd0, cfg_r.timeout_ticks};
      default:           cfg_prdata = 32'd0;
    endcase
  end

  // Handshake: take an item whenever the output register is free or drains
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  slfcr_ctrl #(
    .DEPTH (BUFFER_DEPTH),
    .AW    (AW),
    .PW    (PW)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (accept),
    .func    (in_func),
    .rx_byte (in_rx_byte),
    .cfg     (cfg_r),
    .res     (res),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  slfcr_store #(
    .DEPTH (BUFFER_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en && accept),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_reply_valid    = out_r.reply_valid;
  assign out_reply_byte     = out_r.reply_byte;
  assign out_store_valid    = out_r.store_valid;
  assign out_store_index    = out_r.store_index;
  assign out_frame_done     = out_r.frame_done;
  assign out_frame_state    = out_r.frame_state;
  assign out_timeout_hit    = out_r.timeout_hit;
  assign out_timeout_count  = out_r.timeout_count;
  assign out_expected_total = out_r.expected_total;

endmodule

`default_nettype wire

### rtl/slfcr_store.sv
// ============================================================================
// slfcr_store - frame byte buffer
// Synchronous single-port memory holding the bytes of the current frame.
// ============================================================================
`default_nettype none

module slfcr_store #(
  parameter int DEPTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data
);

  logic [7:0] mem [DEPTH];

  // Byte write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

### rtl/slfcr_ctrl.sv
// ============================================================================
// slfcr_ctrl - frame state machine and watchdog
// Updates the frame state once per accepted item and builds its result item.
// ============================================================================
`default_nettype none

module slfcr_ctrl #(
  parameter int DEPTH = 32,
  parameter int AW    = $clog2(DEPTH),
  parameter int PW    = $clog2(DEPTH + 1)
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                step_en,
  input  wire logic [1:0]          func,
  input  wire logic [7:0]          rx_byte,
  input  wire slfcr_pkg::cfg_t     cfg,
  output slfcr_pkg::result_t       res,
  output logic                     wr_en,
  output logic [AW-1:0]            wr_addr,
  output logic [7:0]               wr_data
);

  import slfcr_pkg::*;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_RECV = 2'd1,
    MODE_HELD = 2'd2
  } mode_t;

  mode_t         mode_r, mode_nxt;
  logic [PW-1:0] pos_r, pos_nxt, pos_cur;
  logic [7:0]    tot_r, tot_nxt;
  logic          armed_r, armed_nxt;
  logic [7:0]    wd_r, wd_nxt, wd_inc;
  logic [7:0]    abort_r, abort_nxt;
  logic          handle;

  assign wr_data = rx_byte;
  assign wd_inc  = wd_r + 8'd1;

  // Next state and result of the current item
  always_comb begin
    mode_nxt  = mode_r;
    pos_nxt   = pos_r;
    pos_cur   = pos_r;
    tot_nxt   = tot_r;
    armed_nxt = armed_r;
    wd_nxt    = wd_r;
    abort_nxt = abort_r;
    handle    = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = pos_r[AW-1:0];
    res       = '0;

    case (func)
      FUNC_BYTE: begin
        if (mode_r == MODE_IDLE) begin
          if (rx_byte == STATUS_REQUEST) begin
            res.reply_valid = 1'b1;
            res.reply_byte  = cfg.status_reply;
          end else begin
            // frame start
            mode_nxt  = MODE_RECV;
            armed_nxt = 1'b1;
            wd_nxt    = 8'd0;
            pos_cur   = '0;
            tot_nxt   = 8'd0;
            handle    = 1'b1;
          end
        end else if (mode_r == MODE_RECV) begin
          handle = 1'b1;
        end

        if (handle) begin
          pos_nxt = pos_cur;
          if (pos_cur == PW'(1)) begin
            tot_nxt = rx_byte + LENGTH_BIAS;
          end
          if (pos_cur < PW'(DEPTH)) begin
            wr_en           = 1'b1;
            wr_addr         = pos_cur[AW-1:0];
            res.store_valid = 1'b1;
            res.store_index = 5'(pos_cur);
            pos_nxt         = pos_cur + PW'(1);
          end else begin
            // buffer full: drop the byte
            res.reply_valid = 1'b1;
            res.reply_byte  = cfg.overflow_code;
          end
          if (9'(pos_nxt) == {1'b0, tot_nxt}) begin
            armed_nxt      = 1'b0;
            mode_nxt       = MODE_HELD;
            res.frame_done = 1'b1;
          end
        end
      end

      FUNC_TICK: begin
        if (armed_r) begin
          wd_nxt = wd_inc;
          if (wd_inc >= cfg.timeout_ticks) begin
            armed_nxt       = 1'b0;
            wd_nxt          = 8'd0;
            mode_nxt        = MODE_IDLE;
            abort_nxt       = abort_r + 8'd1;
            res.timeout_hit = 1'b1;
          end
        end
      end

      FUNC_CONSUME: begin
        if (mode_r == MODE_HELD) begin
          mode_nxt = MODE_IDLE;
        end
      end

      default: begin
      end
    endcase

    res.frame_state    = mode_nxt;
    res.timeout_count  = abort_nxt;
    res.expected_total = tot_nxt;
  end

  // State registers, updated on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      pos_r   <= '0;
      tot_r   <= 8'd0;
      armed_r <= 1'b0;
      wd_r    <= 8'd0;
      abort_r <= 8'd0;
    end else if (step_en) begin
      mode_r  <= mode_nxt;
      pos_r   <= pos_nxt;
      tot_r   <= tot_nxt;
      armed_r <= armed_nxt;
      wd_r    <= wd_nxt;
      abort_r <= abort_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/slfcr_checker.sv
// ============================================================================
// slfcr_checker - port-level checks for the command receiver
// Consistency of result items as seen on the top-level ports.
// ============================================================================
`default_nettype none

module slfcr_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       out_reply_valid,
  input wire logic [7:0] out_reply_byte,
  input wire logic       out_store_valid,
  input wire logic [4:0] out_store_index,
  input wire logic       out_frame_done,
  input wire logic [1:0] out_frame_state,
  input wire logic       out_timeout_hit
);

  // a completed frame is always held
  a_done_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_done |-> out_frame_state == 2'd2)
    else $error("frame done without held state");

  // a watchdog abort always returns to idle, and never with a store
  a_hit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_timeout_hit |-> out_frame_state == 2'd0 && !out_store_valid)
    else $error("watchdog abort not idle");

  // unused reply and index fields read as zero
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_reply_valid || out_reply_byte == 8'd0) &&
                  (out_store_valid || out_store_index == 5'd0))
    else $error("idle field not zero");

  // a stalled result item stays presented
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

endmodule

bind spi_length_framed_command_receiver slfcr_checker u_slfcr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_reply_valid (out_reply_valid),
  .out_reply_byte  (out_reply_byte),
  .out_store_valid (out_store_valid),
  .out_store_index (out_store_index),
  .out_frame_done  (out_frame_done),
  .out_frame_state (out_frame_state),
  .out_timeout_hit (out_timeout_hit)
);

`default_nettype wire

### sim/slfcr_frame_monitor.sv
`timescale 1ns / 1ps
// ============================================================================
// slfcr_frame_monitor - result checker for the SPI length-framed receiver
// Watches the item, result and configuration ports, keeps its own copy of
// the frame state and registers, predicts one result per accepted item and
// compares every returned result field by field in order.
// ============================================================================

module slfcr_frame_monitor (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // item channel
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [1:0]  in_func,
  input  wire logic [7:0]  in_rx_byte,
  // result channel
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic        out_reply_valid,
  input  wire logic [7:0]  out_reply_byte,
  input  wire logic        out_store_valid,
  input  wire logic [4:0]  out_store_index,
  input  wire logic        out_frame_done,
  input  wire logic [1:0]  out_frame_state,
  input  wire logic        out_timeout_hit,
  input  wire logic [7:0]  out_timeout_count,
  input  wire logic [7:0]  out_expected_total,
  // configuration port
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  input  wire logic [31:0] cfg_prdata,
  input  wire logic        cfg_pready,
  // status to the test top
  output int               mismatch_count,
  output int               results_due
);

  import slfcr_pkg::*;

  localparam int DEPTH      = BUFFER_DEPTH_DEF;

  typedef enum logic [1:0] {
    FRAME_IDLE      = 2'd0,
    FRAME_RECEIVING = 2'd1,
    FRAME_HELD      = 2'd2
  } frame_mode_e;

  // register copy and frame state
  cfg_t        regs_q;
  frame_mode_e mode_q;
  logic [5:0]  pos_q;
  logic [7:0]  total_q;
  logic        armed_q;
  logic [7:0]  ticks_q;
  logic [7:0]  aborts_q;

  result_t     frame_results_due[$];
  result_t     got;
  result_t     predicted;
  logic [31:0] readback_want;

  initial begin
    mismatch_count = 0;
    results_due    = 0;
  end

  // one line per problem
  task automatic report_error(input string msg);
    $display("%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got_v,
                             input logic [7:0] want_v);
    if (got_v !== want_v)
      report_error($sformatf("%s: got %0h, expected %0h", name, got_v, want_v));
  endtask

  // advance the frame state by one event and build its result
  task automatic apply_spi_event(input logic [1:0] func, input logic [7:0] rx,
                                 output result_t r);
    logic take;
    r    = '0;
    take = 1'b0;
    case (func)
      FUNC_BYTE: begin
        if (mode_q == FRAME_IDLE) begin
          if (rx == STATUS_REQUEST) begin
            r.reply_valid = 1'b1;
            r.reply_byte  = regs_q.status_reply;
          end else begin
            // frame start: clear position and total, arm the watchdog
            mode_q  = FRAME_RECEIVING;
            armed_q = 1'b1;
            ticks_q = 8'd0;
            pos_q   = 6'd0;
            total_q = 8'd0;
            take    = 1'b1;
          end
        end else if (mode_q == FRAME_RECEIVING) begin
          take = 1'b1;
        end
        if (take) begin
          if (pos_q == 6'd1) total_q = rx + LENGTH_BIAS;
          if (pos_q < DEPTH) begin
            r.store_valid = 1'b1;
            r.store_index = pos_q[4:0];
            pos_q         = pos_q + 6'd1;
          end else begin
            // buffer full: drop the byte
            r.reply_valid = 1'b1;
            r.reply_byte  = regs_q.overflow_code;
          end
          if ({2'b00, pos_q} == total_q) begin
            armed_q      = 1'b0;
            mode_q       = FRAME_HELD;
            r.frame_done = 1'b1;
          end
        end
      end
      FUNC_TICK: begin
        if (armed_q) begin
          ticks_q = ticks_q + 8'd1;
          // a zero limit fires on the first tick like a limit of one
          if (ticks_q >= regs_q.timeout_ticks) begin
            armed_q       = 1'b0;
            ticks_q       = 8'd0;
            mode_q        = FRAME_IDLE;
            aborts_q      = aborts_q + 8'd1;
            r.timeout_hit = 1'b1;
          end
        end
      end
      FUNC_CONSUME: begin
        if (mode_q == FRAME_HELD) mode_q = FRAME_IDLE;
      end
      default: ;
    endcase
    r.frame_state    = mode_q;
    r.timeout_count  = aborts_q;
    r.expected_total = total_q;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      regs_q.status_reply  = STATUS_REPLY_RST;
      regs_q.overflow_code = OVERFLOW_CODE_RST;
      regs_q.timeout_ticks = TIMEOUT_TICKS_RST;
      mode_q   = FRAME_IDLE;
      pos_q    = 6'd0;
      total_q  = 8'd0;
      armed_q  = 1'b0;
      ticks_q  = 8'd0;
      aborts_q = 8'd0;
      frame_results_due.delete();
      results_due <= 0;
    end else begin
      // register writes and read-back
      if (cfg_psel && cfg_penable && cfg_pready) begin
        if (cfg_pwrite) begin
          case (cfg_paddr[3:2])
            REG_STATUS_REPLY:  regs_q.status_reply  = cfg_pwdata[7:0];
            REG_OVERFLOW_CODE: regs_q.overflow_code = cfg_pwdata[7:0];
            REG_TIMEOUT_TICKS: regs_q.timeout_ticks = cfg_pwdata[7:0];
            default: ;
          endcase
        end else begin
          readback_want = '0;
          case (cfg_paddr[3:2])
            REG_STATUS_REPLY:  readback_want[7:0] = regs_q.status_reply;
            REG_OVERFLOW_CODE: readback_want[7:0] = regs_q.overflow_code;
            REG_TIMEOUT_TICKS: readback_want[7:0] = regs_q.timeout_ticks;
            default: ;
          endcase
          if (cfg_prdata !== readback_want)
            report_error($sformatf("register read at %0h: got %0h, expected %0h",
                                   cfg_paddr, cfg_prdata, readback_want));
        end
      end

      // returned result against the oldest prediction
      if (out_valid && out_ready) begin
        got = '{out_reply_valid, out_reply_byte, out_store_valid, out_store_index,
                out_frame_done, out_frame_state, out_timeout_hit,
                out_timeout_count, out_expected_total};
        if (frame_results_due.size() == 0) begin
          report_error("result item arrived with none expected");
        end else begin
          predicted = frame_results_due.pop_front();
          check_field("reply_valid", 8'(got.reply_valid), 8'(predicted.reply_valid));
          check_field("reply_byte", got.reply_byte, predicted.reply_byte);
          check_field("store_valid", 8'(got.store_valid), 8'(predicted.store_valid));
          check_field("store_index", 8'(got.store_index), 8'(predicted.store_index));
          check_field("frame_done", 8'(got.frame_done), 8'(predicted.frame_done));
          check_field("frame_state", 8'(got.frame_state), 8'(predicted.frame_state));
          check_field("timeout_hit", 8'(got.timeout_hit), 8'(predicted.timeout_hit));
          check_field("timeout_count", got.timeout_count, predicted.timeout_count);
          check_field("expected_total", got.expected_total,
                      predicted.expected_total);
        end
      end

      // accepted item: predict its result
      if (in_valid && in_ready) begin
        apply_spi_event(in_func, in_rx_byte, predicted);
        frame_results_due.push_back(predicted);
      end

      results_due <= frame_results_due.size();
    end
  end

endmodule

### sim/tb_spi_length_framed_command_receiver.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_spi_length_framed_command_receiver - test top for the frame receiver
// Drives SPI bytes, ticks and consume events in bursts with random gaps,
// stalls the result side on changing patterns, steps the registers through
// several settings between phases and reports the verdict of the monitor.
// ============================================================================

module tb_spi_length_framed_command_receiver;
  import slfcr_pkg::*;

  localparam logic [1:0] FUNC_RESERVED = 2'd3;
  localparam int         PHASE_ITEMS   = 360;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_MOSTLY,
    READY_SPARSE,
    READY_PERIODIC
  } ready_pattern_e;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_func;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic        out_reply_valid;
  logic [7:0]  out_reply_byte;
  logic        out_store_valid;
  logic [4:0]  out_store_index;
  logic        out_frame_done;
  logic [1:0]  out_frame_state;
  logic        out_timeout_hit;
  logic [7:0]  out_timeout_count;
  logic [7:0]  out_expected_total;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int             mismatch_count;
  int             results_due;
  int             items_sent  = 0;
  int             burst_left  = 0;
  logic [7:0]     cur_timeout = TIMEOUT_TICKS_RST;
  ready_pattern_e ready_pattern = READY_ALWAYS;
  int             ready_cycle = 0;

  spi_length_framed_command_receiver dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_func            (in_func),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_reply_valid    (out_reply_valid),
    .out_reply_byte     (out_reply_byte),
    .out_store_valid    (out_store_valid),
    .out_store_index    (out_store_index),
    .out_frame_done     (out_frame_done),
    .out_frame_state    (out_frame_state),
    .out_timeout_hit    (out_timeout_hit),
    .out_timeout_count  (out_timeout_count),
    .out_expected_total (out_expected_total),
    .cfg_psel           (cfg_psel),
    .cfg_penable        (cfg_penable),
    .cfg_pwrite         (cfg_pwrite),
    .cfg_paddr          (cfg_paddr),
    .cfg_pwdata         (cfg_pwdata),
    .cfg_prdata         (cfg_prdata),
    .cfg_pready         (cfg_pready)
  );

  slfcr_frame_monitor frame_monitor (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_func            (in_func),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_reply_valid    (out_reply_valid),
    .out_reply_byte     (out_reply_byte),
    .out_store_valid    (out_store_valid),
    .out_store_index    (out_store_index),
    .out_frame_done     (out_frame_done),
    .out_frame_state    (out_frame_state),
    .out_timeout_hit    (out_timeout_hit),
    .out_timeout_count  (out_timeout_count),
    .out_expected_total (out_expected_total),
    .cfg_psel           (cfg_psel),
    .cfg_penable        (cfg_penable),
    .cfg_pwrite         (cfg_pwrite),
    .cfg_paddr          (cfg_paddr),
    .cfg_pwdata         (cfg_pwdata),
    .cfg_prdata         (cfg_prdata),
    .cfg_pready         (cfg_pready),
    .mismatch_count     (mismatch_count),
    .results_due        (results_due)
  );

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // result side: out_ready follows a ready pattern that is redrawn at random
  always @(posedge clk) begin
    ready_cycle <= ready_cycle + 1;
    if (ready_cycle % 250 == 0)
      ready_pattern <= ready_pattern_e'($urandom_range(0, 3));
    case (ready_pattern)
      READY_ALWAYS:   out_ready <= 1'b1;
      READY_MOSTLY:   out_ready <= ($urandom_range(0, 3) != 0);
      READY_SPARSE:   out_ready <= ($urandom_range(0, 3) == 0);
      default:        out_ready <= ((ready_cycle % 7) < 4);
    endcase
  end

  // one item; a new burst may open with an idle gap
  task automatic send_item(input logic [1:0] func, input logic [7:0] rx);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid   <= 1'b1;
    in_func    <= func;
    in_rx_byte <= rx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_ticks(input int count);
    repeat (count) send_item(FUNC_TICK, 8'($urandom_range(0, 255)));
  endtask

  // enough ticks to expire the watchdog from any point of a frame
  function automatic int abort_ticks();
    return (cur_timeout == 8'd0) ? 1 : int'(cur_timeout);
  endfunction

  // wait until every result is back
  task automatic wait_idle();
    do @(posedge clk); while (results_due != 0);
    repeat (4) @(posedge clk);
  endtask

  // one APB transfer; psel stays up for the next transfer
  task automatic cfg_access(input logic wr, input logic [1:0] idx,
                            input logic [7:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= wr ? {24'd0, val} : 32'd0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
  endtask

  task automatic configure(input logic [7:0] status, input logic [7:0] ovf,
                           input logic [7:0] tmo);
    in_valid  <= 1'b0;
    burst_left = 0;
    wait_idle();
    cfg_access(1'b1, REG_STATUS_REPLY, status);
    cfg_access(1'b1, REG_OVERFLOW_CODE, ovf);
    cfg_access(1'b1, REG_TIMEOUT_TICKS, tmo);
    cfg_access(1'b0, REG_STATUS_REPLY, 8'h00);
    cfg_access(1'b0, REG_OVERFLOW_CODE, 8'h00);
    cfg_access(1'b0, REG_TIMEOUT_TICKS, 8'h00);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cur_timeout = tmo;
  endtask

  // start byte, length byte, payload with stray ticks, then usually a consume;
  // totals out of reach or past the buffer end in a watchdog abort
  task automatic send_frame(input logic [7:0] len);
    int payload;
    payload = (len > 8'd36) ? 36 : int'(len);
    send_item(FUNC_BYTE, 8'($urandom_range(0, 254)));
    send_item(FUNC_BYTE, len);
    repeat (payload) begin
      if ($urandom_range(0, 11) == 0) send_item(FUNC_TICK, 8'($urandom_range(0, 255)));
      send_item(FUNC_BYTE, 8'($urandom_range(0, 255)));
    end
    if (len > 8'd30) begin
      send_ticks(abort_ticks());
    end else begin
      if ($urandom_range(0, 2) == 0) send_item(FUNC_BYTE, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 3) == 0) send_item(FUNC_TICK, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 7) != 0)
        send_item(FUNC_CONSUME, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic run_random(input int target);
    int stop;
    int pick;
    int sel;
    stop = items_sent + target;
    send_frame(8'd40);
    while (items_sent < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        sel = $urandom_range(0, 99);
        if (sel < 70)      send_frame(8'($urandom_range(0, 12)));
        else if (sel < 85) send_frame(8'($urandom_range(13, 30)));
        else if (sel < 93) send_frame(8'($urandom_range(31, 60)));
        else               send_frame(8'($urandom_range(253, 255)));
      end else if (pick < 65) begin
        send_item(FUNC_BYTE, STATUS_REQUEST);
      end else if (pick < 75) begin
        // frame cut short by the watchdog
        send_item(FUNC_BYTE, 8'($urandom_range(0, 254)));
        repeat ($urandom_range(0, 3)) send_item(FUNC_BYTE, 8'($urandom_range(0, 255)));
        send_ticks(abort_ticks());
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 4))
          send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end else begin
        send_item(pick[0] ? FUNC_CONSUME : FUNC_TICK, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_func     <= FUNC_BYTE;
    in_rx_byte  <= 8'h00;
    out_ready   <= 1'b0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= 4'd0;
    cfg_pwdata  <= 32'd0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed, register defaults
    send_item(FUNC_TICK, 8'h00);          // tick, watchdog disarmed
    send_item(FUNC_CONSUME, 8'hFF);       // consume with nothing held
    send_item(FUNC_RESERVED, 8'hFF);      // unused function code
    send_item(FUNC_BYTE, STATUS_REQUEST); // status request while idle
    send_item(FUNC_BYTE, 8'h00);          // shortest frame, total 2
    send_item(FUNC_BYTE, 8'h00);
    send_item(FUNC_BYTE, STATUS_REQUEST); // ignored while held
    send_item(FUNC_TICK, 8'hFF);
    send_item(FUNC_CONSUME, 8'h00);

    configure(8'hA5, 8'h5A, 8'd2);
    send_item(FUNC_BYTE, STATUS_REQUEST);
    send_item(FUNC_BYTE, 8'hFE);          // total wraps to 0
    send_item(FUNC_BYTE, 8'hFE);
    send_ticks(2);
    send_item(FUNC_BYTE, 8'h7F);          // total wraps to 1
    send_item(FUNC_BYTE, 8'hFF);
    send_item(FUNC_BYTE, 8'h80);
    send_ticks(2);
    send_item(FUNC_BYTE, 8'h01);          // total 3, 0xFF as data
    send_item(FUNC_BYTE, 8'h01);
    send_item(FUNC_BYTE, STATUS_REQUEST);
    send_item(FUNC_CONSUME, 8'h00);

    configure(8'h00, 8'hFF, 8'd0);        // zero timeout fires on first tick
    send_item(FUNC_BYTE, 8'h40);
    send_item(FUNC_TICK, 8'h00);

    // random phases over a spread of settings
    configure(8'hFF, 8'h00, 8'd1);
    run_random(PHASE_ITEMS);
    configure(8'h00, 8'hFF, 8'd255);
    run_random(PHASE_ITEMS);
    configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(2, 30)));
    run_random(PHASE_ITEMS);
    configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              TIMEOUT_TICKS_RST);
    run_random(PHASE_ITEMS);

    // drain and settle
    in_valid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
    repeat (20) @(posedge clk);

    if (mismatch_count == 0 && results_due == 0) begin
      $display("tb_spi_length_framed_command_receiver: clean");
    end else begin
      $display("tb_spi_length_framed_command_receiver: errors");
    end
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("tb_spi_length_framed_command_receiver: errors");
    $finish;
  end

endmodule

### spi_length_framed_command_receiver.f
rtl/slfcr_pkg.sv
rtl/slfcr_store.sv
rtl/slfcr_ctrl.sv
rtl/spi_length_framed_command_receiver.sv
rtl/slfcr_checker.sv
sim/slfcr_frame_monitor.sv
sim/tb_spi_length_framed_command_receiver.sv
